[hw/rtl/assert_macros.svh]
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion, disabled while the active-low reset is low
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define ASSERT_CLK(label, prop, msg) \
    `ASSERT_IMPL(label, i_clk, i_rst_n, prop, msg)

`endif

[hw/rtl/cbsf_pkg.sv]
// package with constants, types and functions of the crc byte stuffing framer
package cbsf_pkg;

    localparam logic [7:0]  START_BYTE = 8'h0A;
    localparam logic [7:0]  END_BYTE   = 8'h0D;
    localparam logic [7:0]  ESC_BYTE   = 8'h10;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam int          MAX_BYTES  = 8;
    localparam int          CNT_W      = $clog2(MAX_BYTES + 1);

    typedef logic [CNT_W-1:0] t_cnt;

    // one body or crc byte after stuffing
    typedef struct packed {
        logic       esc;
        logic [7:0] value;
    } t_stuff;

    // bytes produced by one item plus the frame state it leaves
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        t_cnt                      count;
        logic                      frame_end;
        logic [15:0]               crc_next;
        logic                      in_frame_next;
    } t_expand;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic t_stuff stuff(input logic [7:0] b);
        t_stuff s;
        s.esc   = (b == START_BYTE) || (b == END_BYTE) || (b == ESC_BYTE);
        s.value = s.esc ? ~b : b;
        return s;
    endfunction

endpackage

[hw/rtl/cbsf_expand.sv]
// expands one body byte into its framed, stuffed output bytes and updates the crc
module cbsf_expand (
    input  logic [7:0]       i_data,
    input  logic             i_last,
    input  logic             i_in_frame,
    input  logic [15:0]      i_crc,
    input  logic             i_skip_first,
    output cbsf_pkg::t_expand o_exp
);
    import cbsf_pkg::*;

    logic [15:0] crc_base;
    logic [15:0] crc_new;
    logic        fold;
    t_stuff      s_data;
    t_stuff      s_lo;
    t_stuff      s_hi;
    logic [MAX_BYTES-1:0][7:0] bytes;
    t_cnt        pos;

    always_comb begin
        crc_base = i_in_frame ? i_crc : CRC_INIT;
        fold     = i_in_frame || !i_skip_first;
        crc_new  = fold ? crc_fold(crc_base, i_data) : crc_base;
        s_data   = stuff(i_data);
        s_lo     = stuff(crc_new[7:0]);
        s_hi     = stuff(crc_new[15:8]);
    end

    always_comb begin
        bytes = '0;
        pos   = '0;
        if (!i_in_frame) begin
            bytes[pos[2:0]] = START_BYTE;
            pos = pos + t_cnt'(1);
        end
        if (s_data.esc) begin
            bytes[pos[2:0]] = ESC_BYTE;
            pos = pos + t_cnt'(1);
        end
        bytes[pos[2:0]] = s_data.value;
        pos = pos + t_cnt'(1);
        if (i_last) begin
            if (s_lo.esc) begin
                bytes[pos[2:0]] = ESC_BYTE;
                pos = pos + t_cnt'(1);
            end
            bytes[pos[2:0]] = s_lo.value;
            pos = pos + t_cnt'(1);
            if (s_hi.esc) begin
                bytes[pos[2:0]] = ESC_BYTE;
                pos = pos + t_cnt'(1);
            end
            bytes[pos[2:0]] = s_hi.value;
            pos = pos + t_cnt'(1);
            bytes[pos[2:0]] = END_BYTE;
            pos = pos + t_cnt'(1);
        end
    end

    always_comb begin
        o_exp.bytes         = bytes;
        o_exp.count         = pos;
        o_exp.frame_end     = i_last;
        o_exp.crc_next      = i_last ? CRC_INIT : crc_new;
        o_exp.in_frame_next = !i_last;
    end

endmodule

[hw/rtl/crc_byte_stuffing_framer.sv]
// top level of the crc byte stuffing framer
//
//  channel  | direction | signals                               | content
//  s_axis   | in        | s_axis_tvalid/tready/tdata/tlast      | body byte, last body byte
//  m_axis   | out       | m_axis_tvalid/tready/tdata/tlast      | framed byte, closing byte
//  cfg      | in        | i_cfg_valid/o_cfg_ready/i_cfg_data    | crc_skip_first
//
//  an item is held in an input register, then expanded combinationally into 1 to 8 bytes
//  that go into an output shift buffer; the output drains one byte per cycle while
//  m_axis_tready is high; an item produces 1 byte for a plain mid-frame byte and up
//  to 8 for a single-byte frame; the output port sets the rate
//  a new item is loaded when the buffer is empty or while its last byte is being taken
//  reset clears the frame state and valid flags, sets the crc to CRC_INIT and sets crc_skip_first
module crc_byte_stuffing_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import cbsf_pkg::*;

    `include "assert_macros.svh"

    logic        r_skip_first;
    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [15:0] r_crc;
    logic        r_in_frame;
    logic [MAX_BYTES-1:0][7:0] r_buf;
    t_cnt        r_cnt;
    logic        r_buf_end;

    t_expand     exp;
    logic        in_acc;
    logic        out_acc;
    logic        load;

    cbsf_expand u_expand (
        .i_data       (r_in_data),
        .i_last       (r_in_last),
        .i_in_frame   (r_in_frame),
        .i_crc        (r_crc),
        .i_skip_first (r_skip_first),
        .o_exp        (exp)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_buf[0];
    assign m_axis_tlast  = r_buf_end && (r_cnt == t_cnt'(1));

    assign out_acc = m_axis_tvalid && m_axis_tready;
    // buffer free now or freed by the byte leaving this cycle
    assign load    = r_in_valid && ((r_cnt == '0) || ((r_cnt == t_cnt'(1)) && m_axis_tready));
    assign s_axis_tready = !r_in_valid || load;
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_first <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_skip_first <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
            r_buf_end  <= 1'b0;
        end else if (load) begin
            r_crc      <= exp.crc_next;
            r_in_frame <= exp.in_frame_next;
            r_cnt      <= exp.count;
            r_buf_end  <= exp.frame_end;
        end else if (out_acc) begin
            r_cnt <= r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= exp.bytes;
        end else if (out_acc) begin
            r_buf <= r_buf >> 8;
        end
    end

    `ASSERT_CLK(a_cnt_range, r_cnt <= t_cnt'(MAX_BYTES), "output byte count out of range")
    `ASSERT_CLK(a_load_free, load |-> (r_cnt == '0) || out_acc && r_cnt == t_cnt'(1), "buffer busy")
    `ASSERT_CLK(a_last_end, m_axis_tlast |-> m_axis_tdata == END_BYTE, "tlast not on end byte")
    `ASSERT_CLK(a_last_idle, m_axis_tlast |-> !r_in_frame && r_crc == CRC_INIT, "frame not closed")

endmodule
